>>> design/sac_pkg.sv
// shared types and constants of the set associative cache tag controller
`timescale 1ns / 1ps
package sac_pkg;

  localparam int unsigned IN_ADDR_W  = 48;
  localparam int unsigned OUT_WAY_W  = 3;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE   = 8'd1;

  localparam logic REPL_LRU  = 1'b0;
  localparam logic REPL_FIFO = 1'b1;
  localparam logic WR_THROUGH = 1'b0;
  localparam logic WR_BACK    = 1'b1;
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic replace_policy;
    logic wr_mode;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic                 mem_read;
    logic                 mem_write;
    logic [OUT_WAY_W-1:0] way_used;
  } rsp_t;

endpackage

>>> design/sac_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sac_fifo.sv
// small register queue with push/full and pop/empty sides
`timescale 1ns / 1ps
module sac_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> design/sac_front.sv
// front end: splits the address into set and tag and queues the request
`timescale 1ns / 1ps
module sac_front #(
  parameter int unsigned SET_W     = 6,
  parameter int unsigned SET_BITS  = 6,
  parameter int unsigned TAG_W     = 36,
  parameter int unsigned OFF_BITS  = 6,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic                              hold,
  input  logic                              req_type,
  input  logic [sac_pkg::IN_ADDR_W-1:0]     address,
  output logic                              full,
  input  logic                              pop,
  output logic [TAG_W+SET_W:0]              req_data,
  output logic                              empty
);

  localparam logic [63:0] ADDR_MASK =
    (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [63:0] SET_MASK = (64'd1 << SET_BITS) - 64'd1;

  logic [63:0] addr_m, line, set_full, tag_full;
  logic        q_full;

  always_comb begin
    addr_m   = 64'(address) & ADDR_MASK;
    line     = addr_m >> OFF_BITS;
    set_full = line & SET_MASK;
    tag_full = line >> SET_BITS;
  end

  assign full = q_full || hold;

  sac_fifo #(.WIDTH(TAG_W + SET_W + 1), .DEPTH(2)) u_req_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push && !hold),
    .push_data ({req_type, set_full[SET_W-1:0], tag_full[TAG_W-1:0]}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (req_data),
    .empty     (empty)
  );

endmodule

>>> design/sac_back.sv
// back end: set lookup, victim choice, rank upkeep and tag ram writes
`timescale 1ns / 1ps
module sac_back #(
  parameter int unsigned SETS  = 64,
  parameter int unsigned WAYS  = 8,
  parameter int unsigned SET_W = 6,
  parameter int unsigned TAG_W = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sac_pkg::cfg_t        cfg,
  input  logic [TAG_W+SET_W:0] req_data,
  input  logic                 req_empty,
  output logic                 req_pop,
  output logic                 clearing,
  output logic                 rsp_push,
  output sac_pkg::rsp_t        rsp,
  input  logic                 rsp_full
);

  localparam int unsigned RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              valid;
    logic              dirty;
    logic [RANK_W-1:0] lru;
    logic [RANK_W-1:0] fill;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_LOOK, S_UPD} state_t;

  state_t            state_r;
  logic [SET_W-1:0]  clr_cnt_r;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic              is_wr_r;
  logic              hit_r;
  logic [RANK_W-1:0] way_r;
  row_t              row_r;

  row_t              rd_row, clr_row, new_row;
  logic [$bits(row_t)-1:0] rdata;
  logic              found;
  logic [RANK_W-1:0] hit_way, inv_way, lru_v, fifo_v, victim;
  logic              any_inv;
  logic              mwr;
  logic [RANK_W-1:0] old_rank;
  logic              ram_we;
  logic [SET_W-1:0]  ram_waddr;
  logic [$bits(row_t)-1:0] ram_wdata;
  logic [RANK_W+2:0] way_ext;

  assign rd_row = row_t'(rdata);

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      clr_row[i]      = '0;
      clr_row[i].lru  = RANK_W'(i);
      clr_row[i].fill = RANK_W'(i);
    end
  end

  // lookup on the row just read
  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    lru_v   = '0;
    fifo_v  = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rd_row[i].valid && rd_row[i].tag == tag_r) begin
        found   = 1'b1;
        hit_way = RANK_W'(i);
      end
      if (!rd_row[i].valid) begin
        any_inv = 1'b1;
        inv_way = RANK_W'(i);
      end
    end
    for (int i = 1; i < WAYS; i++) begin
      if (rd_row[i].lru > rd_row[lru_v].lru) lru_v = RANK_W'(i);
      if (rd_row[i].fill < rd_row[fifo_v].fill) fifo_v = RANK_W'(i);
    end
    if (any_inv) begin
      victim = inv_way;
    end else if (cfg.replace_policy == sac_pkg::REPL_FIFO) begin
      victim = fifo_v;
    end else begin
      victim = lru_v;
    end
  end

  // row update for the chosen way
  always_comb begin
    new_row = row_r;
    mwr     = 1'b0;
    if (hit_r) begin
      if (is_wr_r) begin
        if (cfg.wr_mode == sac_pkg::WR_BACK) new_row[way_r].dirty = 1'b1;
        else mwr = 1'b1;
      end
    end else begin
      mwr = row_r[way_r].valid && row_r[way_r].dirty &&
            (cfg.wr_mode == sac_pkg::WR_BACK);
      new_row[way_r].tag   = tag_r;
      new_row[way_r].valid = 1'b1;
      new_row[way_r].dirty = is_wr_r && (cfg.wr_mode == sac_pkg::WR_BACK);
      if (is_wr_r && cfg.wr_mode == sac_pkg::WR_THROUGH) mwr = 1'b1;
    end
    if (cfg.replace_policy == sac_pkg::REPL_LRU) begin
      old_rank = row_r[way_r].lru;
      for (int i = 0; i < WAYS; i++) begin
        if (row_r[i].lru < old_rank) new_row[i].lru = row_r[i].lru + 1'b1;
      end
      new_row[way_r].lru = '0;
    end else begin
      old_rank = row_r[way_r].fill;
      // fill order moves only on a fill
      if (!hit_r) begin
        for (int i = 0; i < WAYS; i++) begin
          if (row_r[i].fill > old_rank) new_row[i].fill = row_r[i].fill - 1'b1;
        end
        new_row[way_r].fill = RANK_W'(WAYS - 1);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = new_row;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = clr_row;
      end
      S_UPD:   ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  sac_ram #(.WIDTH($bits(row_t)), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (req_data[TAG_W +: SET_W]),
    .rdata (rdata)
  );

  assign clearing = (state_r == S_CLR);
  assign req_pop  = (state_r == S_IDLE) && !req_empty && !rsp_full;
  assign rsp_push = (state_r == S_UPD);
  assign way_ext  = (RANK_W + 3)'(way_r);

  always_comb begin
    rsp.hit       = hit_r;
    rsp.mem_read  = !hit_r;
    rsp.mem_write = mwr;
    rsp.way_used  = way_ext[sac_pkg::OUT_WAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SET_W'(SETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (req_pop) state_r <= S_LOOK;
        end
        S_LOOK:  state_r <= S_UPD;
        S_UPD:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      is_wr_r <= (req_data[TAG_W+SET_W] == sac_pkg::REQ_WRITE);
      set_r   <= req_data[TAG_W +: SET_W];
      tag_r   <= req_data[TAG_W-1:0];
    end
    if (state_r == S_LOOK) begin
      row_r <= rd_row;
      hit_r <= found;
      way_r <= found ? hit_way : victim;
    end
  end

endmodule

>>> design/set_assoc_cache_tag_controller_top.sv
// top level of the set associative cache tag controller
`timescale 1ns / 1ps
// Accesses enter through a queue port: present in_req_type and in_address
// and raise in_push; the item is taken on a clock edge where in_full is low.
// Each access gives exactly one result (hit, mem_read, mem_write, way_used),
// read from a result queue: it is valid while out_empty is low and taken on
// an edge with out_pop high. Policies are written through cfg_we, cfg_index
// and cfg_wdata (bit 0 kept); the user must write them only while no access
// is in flight, which the block itself does not enforce. Each access goes
// through the read, lookup and write-back steps on the single write port set
// ram that holds all ways of a set in one row; the next is popped only after
// that write-back, and not while the result queue is full. After reset a
// clearing pass writes every set row, while in_full stays high. Two-entry
// queues sit on both sides, so a stalled receiver first fills the result
// queue, then the request queue, and then in_full rises; nothing is dropped.
module set_assoc_cache_tag_controller_top #(
  parameter int unsigned SETS       = 64,
  parameter int unsigned WAYS       = 8,
  parameter int unsigned LINE_BYTES = 64,
  parameter int unsigned ADDR_BITS  = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_req_type,
  input  logic [sac_pkg::IN_ADDR_W-1:0]   in_address,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_hit,
  output logic                            out_mem_read,
  output logic                            out_mem_write,
  output logic [sac_pkg::OUT_WAY_W-1:0]   out_way_used,
  input  logic                            cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                            cfg_wdata
);

  localparam int unsigned SET_BITS = $clog2(SETS);
  localparam int unsigned SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned OFF_BITS = $clog2(LINE_BYTES);
  localparam int          TAG_RAW  = int'(ADDR_BITS) - int'(OFF_BITS) - int'(SET_BITS);
  localparam int unsigned TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;

  sac_pkg::cfg_t cfg_r;
  sac_pkg::rsp_t rsp, out_rsp;
  logic [TAG_W+SET_W:0] req_data;
  logic req_empty, req_pop, clearing, rsp_push, rsp_full;
  logic [$bits(sac_pkg::rsp_t)-1:0] out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == sac_pkg::CFG_REPLACE) cfg_r.replace_policy <= cfg_wdata;
      if (cfg_index == sac_pkg::CFG_WRITE)   cfg_r.wr_mode        <= cfg_wdata;
    end
  end

  sac_front #(
    .SET_W(SET_W), .SET_BITS(SET_BITS), .TAG_W(TAG_W),
    .OFF_BITS(OFF_BITS), .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .hold     (clearing),
    .req_type (in_req_type),
    .address  (in_address),
    .full     (in_full),
    .pop      (req_pop),
    .req_data (req_data),
    .empty    (req_empty)
  );

  sac_back #(
    .SETS(SETS), .WAYS(WAYS), .SET_W(SET_W), .TAG_W(TAG_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_data  (req_data),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .clearing  (clearing),
    .rsp_push  (rsp_push),
    .rsp       (rsp),
    .rsp_full  (rsp_full)
  );

  sac_fifo #(.WIDTH($bits(sac_pkg::rsp_t)), .DEPTH(2)) u_rsp_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rsp_push),
    .push_data (rsp),
    .full      (rsp_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

  assign out_rsp       = sac_pkg::rsp_t'(out_data);
  assign out_hit       = out_rsp.hit;
  assign out_mem_read  = out_rsp.mem_read;
  assign out_mem_write = out_rsp.mem_write;
  assign out_way_used  = out_rsp.way_used;

endmodule

>>> sim/tb.sv
// testbench of the set associative cache tag controller: directed table, random traffic, predictor
`timescale 1ns / 1ps
module tb;

  localparam int SETS = 64;
  localparam int WAYS = 8;
  localparam int LINE_BYTES = 64;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_req_type = 1'b0;
  logic [sac_pkg::IN_ADDR_W-1:0] in_address = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_hit, out_mem_read, out_mem_write;
  logic [sac_pkg::OUT_WAY_W-1:0] out_way_used;
  logic cfg_we = 1'b0;
  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic cfg_wdata = 1'b0;

  set_assoc_cache_tag_controller_top DUT (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_req_type(in_req_type), .in_address(in_address), .out_empty(out_empty),
    .out_pop(out_pop), .out_hit(out_hit), .out_mem_read(out_mem_read),
    .out_mem_write(out_mem_write), .out_way_used(out_way_used), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the tag state
  logic [35:0] tags [SETS][WAYS];
  logic valid [SETS][WAYS];
  logic dirty [SETS][WAYS];
  logic [2:0] lru [SETS][WAYS];
  logic [2:0] fill [SETS][WAYS];
  logic repl_pol = sac_pkg::REPL_LRU;
  logic wr_pol = sac_pkg::WR_THROUGH;

  sac_pkg::rsp_t access_results [$];
  int errors = 0;
  int accepted = 0;
  int popped = 0;
  int hits = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  // directed rows: checked against a typed-in result where has_exp is set
  typedef struct {
    logic rw;
    logic [47:0] addr;
    bit has_exp;
    sac_pkg::rsp_t exp;
  } dir_row_t;

  function automatic void touch_rank(int s, int w);
    logic [2:0] old;
    old = lru[s][w];
    for (int i = 0; i < WAYS; i++) if (lru[s][i] < old) lru[s][i]++;
    lru[s][w] = '0;
  endfunction

  function automatic sac_pkg::rsp_t cache_access(logic rw, logic [47:0] addr);
    sac_pkg::rsp_t r;
    logic [41:0] line;
    int s;
    int w;
    logic [35:0] tg;
    bit found;
    line = 42'(addr / LINE_BYTES);
    s = int'(line % SETS);
    tg = 36'(line / SETS);
    found = 1'b0;
    w = 0;
    r = '0;
    for (int i = 0; i < WAYS; i++)
      if (!found && valid[s][i] && tags[s][i] == tg) begin
        found = 1'b1;
        w = i;
      end
    if (found) begin
      r.hit = 1'b1;
      if (repl_pol == sac_pkg::REPL_LRU) touch_rank(s, w);
      if (rw == sac_pkg::REQ_WRITE) begin
        if (wr_pol == sac_pkg::WR_BACK) dirty[s][w] = 1'b1;
        else r.mem_write = 1'b1;
      end
    end else begin
      r.mem_read = 1'b1;
      found = 1'b0;
      for (int i = 0; i < WAYS; i++)
        if (!found && !valid[s][i]) begin
          found = 1'b1;
          w = i;
        end
      if (!found) begin
        w = 0;
        for (int i = 1; i < WAYS; i++)
          if (repl_pol == sac_pkg::REPL_LRU ? lru[s][i] > lru[s][w]
                                            : fill[s][i] < fill[s][w]) w = i;
      end
      if (valid[s][w] && dirty[s][w] && wr_pol == sac_pkg::WR_BACK) r.mem_write = 1'b1;
      tags[s][w] = tg;
      valid[s][w] = 1'b1;
      dirty[s][w] = (rw == sac_pkg::REQ_WRITE && wr_pol == sac_pkg::WR_BACK);
      if (rw == sac_pkg::REQ_WRITE && wr_pol == sac_pkg::WR_THROUGH) r.mem_write = 1'b1;
      if (repl_pol == sac_pkg::REPL_LRU) touch_rank(s, w);
      else begin
        logic [2:0] old;
        old = fill[s][w];
        for (int i = 0; i < WAYS; i++) if (fill[s][i] > old) fill[s][i]--;
        fill[s][w] = 3'(WAYS - 1);
      end
    end
    r.way_used = w[2:0];
    return r;
  endfunction

  // sends one access, waiting for acceptance; push stays high for the next one
  task automatic send_access(logic rw, logic [47:0] addr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_push <= 1'b1;
    in_req_type <= rw;
    in_address <= addr;
    @(posedge clk);
    while (in_full) @(posedge clk);
    access_results.push_back(cache_access(rw, addr));
    accepted++;
  endtask

  task automatic drain;
    in_push <= 1'b0;
    while (access_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [sac_pkg::CFG_IDX_W-1:0] idx, logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == sac_pkg::CFG_REPLACE) repl_pol = val;
    else if (idx == sac_pkg::CFG_WRITE) wr_pol = val;
  endtask

  // address in a chosen set with a small tag pool, so sets fill and evict
  function automatic logic [47:0] hot_addr(int set_pool, int tag_pool);
    logic [47:0] a;
    a = 48'({$urandom, $urandom});
    a[11:6] = 6'($urandom_range(set_pool - 1));
    a[47:12] = 36'($urandom_range(tag_pool - 1));
    if ($urandom_range(19) == 0) a[47:12] = 36'({$urandom, $urandom});
    return a;
  endfunction

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      sac_pkg::rsp_t e;
      popped++;
      if (access_results.size() == 0) begin
        $display("%0t result with none expected: hit %b rd %b wr %b way %0d", $time,
                 out_hit, out_mem_read, out_mem_write, out_way_used);
        errors++;
      end else begin
        e = access_results.pop_front();
        if (e.hit) hits++;
        if ({out_hit, out_mem_read, out_mem_write, out_way_used} != e) begin
          $display("%0t mismatch: expected hit %b rd %b wr %b way %0d, got %b %b %b %0d",
                   $time, e.hit, e.mem_read, e.mem_write, e.way_used,
                   out_hit, out_mem_read, out_mem_write, out_way_used);
          errors++;
        end
      end
    end
  end

  // receiver idling
  always @(posedge clk) begin
    out_pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t r;
    sac_pkg::rsp_t x;
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        tags[s][w] = '0;
        valid[s][w] = 1'b0;
        dirty[s][w] = 1'b0;
        lru[s][w] = 3'(w);
        fill[s][w] = 3'(w);
      end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: cold misses, hits, extremes, nine tags into one set to evict
    r = '{sac_pkg::REQ_READ, 48'h0, 1, '{1'b0, 1'b1, 1'b0, 3'd0}}; rows.push_back(r);
    r = '{sac_pkg::REQ_READ, 48'h3f, 1, '{1'b1, 1'b0, 1'b0, 3'd0}}; rows.push_back(r);
    r = '{sac_pkg::REQ_WRITE, 48'h0, 1, '{1'b1, 1'b0, 1'b1, 3'd0}}; rows.push_back(r);
    r = '{sac_pkg::REQ_WRITE, 48'hffff_ffff_ffff, 1, '{1'b0, 1'b1, 1'b1, 3'd0}};
    rows.push_back(r);
    r = '{sac_pkg::REQ_READ, 48'hffff_ffff_ffc0, 1, '{1'b1, 1'b0, 1'b0, 3'd0}};
    rows.push_back(r);
    r = '{sac_pkg::REQ_READ, 48'haaaa_aaaa_aaaa, 0, '0}; rows.push_back(r);
    r = '{sac_pkg::REQ_WRITE, 48'h5555_5555_5555, 0, '0}; rows.push_back(r);
    for (int t = 1; t <= 9; t++) begin
      r = '{(t % 2 == 1) ? sac_pkg::REQ_WRITE : sac_pkg::REQ_READ, 48'(t) << 12, 0, '0};
      rows.push_back(r);
    end
    r = '{sac_pkg::REQ_READ, 48'h0, 0, '0}; rows.push_back(r);
    foreach (rows[i]) begin
      send_access(rows[i].rw, rows[i].addr);
      if (rows[i].has_exp) begin
        x = access_results[$];
        if (x != rows[i].exp) begin
          $display("%0t directed row %0d: expected %h, predictor %h", $time, i,
                   rows[i].exp, x);
          errors++;
        end
      end
    end
    drain();

    // policy sweep with the three idling phases
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(sac_pkg::CFG_REPLACE, ph[0]);
      write_reg(sac_pkg::CFG_WRITE, ph[1]);
      if (ph == 5) write_reg(sac_pkg::CFG_IDX_W'(7), 1'b1);
      send_idle_pct = (ph < 4) ? 7 : (ph < 8) ? 83 : 0;
      recv_idle_pct = (ph < 4) ? 83 : (ph < 8) ? 7 : 0;
      if (ph == 9) begin
        fork
          begin
            recv_hold = 1'b1;
            repeat (60) @(posedge clk);
            recv_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 86; n++)
        send_access(1'($urandom_range(1)), (ph == 11) ? 48'({$urandom, $urandom})
                                                      : hot_addr(ph < 6 ? 2 : 8, 12));
      drain();
    end
    write_reg(sac_pkg::CFG_REPLACE, sac_pkg::REPL_LRU);
    write_reg(sac_pkg::CFG_WRITE, sac_pkg::WR_THROUGH);

    $display("%0d accesses, %0d results, %0d hits, over all four policy mixes",
             accepted, popped, hits);
    if (errors == 0 && access_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
